### hdl/vfr_pkg.sv
package vfr_pkg;

    localparam int          MAX_PAYLOAD_DEF = 12;
    localparam int          CAPTURE_BYTES   = 5;
    localparam logic [7:0]  HDR0            = 8'h55;
    localparam logic [7:0]  HDR1            = 8'hAA;
    localparam logic [7:0]  CRC_POLY        = 8'h8C;
    localparam logic [14:0] LIMIT_RESET     = 15'd500;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_PAY  = 3'd2,
        PH_CRC  = 3'd3,
        PH_TR0  = 3'd4,
        PH_TR1  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_CRC = 2'd1,
        ST_LEN = 2'd2
    } t_status;

    // One completed frame or one rejected frame, seen by the top level.
    typedef struct packed {
        logic                                valid;
        t_status                             status;
        logic [CAPTURE_BYTES-1:0][7:0]       payload;
    } t_frame_evt;

    // Reflected CRC-8, polynomial 0x8C, one byte per call.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    localparam logic [7:0] CRC_HDR = crc8_update(crc8_update(8'h00, HDR0), HDR1);

endpackage

### hdl/vfr_if.sv
interface vfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface vfr_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [7:0]         ctrl_flag;

    modport source (output valid, output status, output left_speed, output right_speed,
                    output ctrl_flag, input ready);
    modport sink   (input valid, input status, input left_speed, input right_speed,
                    input ctrl_flag, output ready);
endinterface

### hdl/vfr_sat.sv
module vfr_sat (
    input  logic [7:0]         i_lo,
    input  logic [7:0]         i_hi,
    input  logic [14:0]        i_limit,
    output logic signed [15:0] o_speed
);

    logic signed [16:0] w_raw;
    logic signed [16:0] w_pos;
    logic signed [16:0] w_neg;
    logic signed [16:0] w_sel;

    assign w_raw = 17'(signed'({i_hi, i_lo}));
    assign w_pos = signed'({2'b00, i_limit});
    assign w_neg = -w_pos;

    always_comb begin
        priority if (w_raw > w_pos) begin
            w_sel = w_pos;
        end else if (w_raw < w_neg) begin
            w_sel = w_neg;
        end else begin
            w_sel = w_raw;
        end
    end

    // The limit is at most 32767, so the result always fits in 16 bits.
    assign o_speed = w_sel[15:0];

endmodule

### hdl/vfr_parser.sv
module vfr_parser #(
    parameter int MAX_PAYLOAD = vfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    output vfr_pkg::t_frame_evt o_evt
);

    localparam int LW = $clog2(MAX_PAYLOAD + 1);

    vfr_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_prev, n_prev;
    logic [LW-1:0]   r_len, n_len;
    logic [LW-1:0]   r_cnt, n_cnt;
    logic [7:0]      r_crc, n_crc;
    logic [7:0]      r_payload [vfr_pkg::CAPTURE_BYTES];

    logic [7:0]      w_crc_next;
    logic            w_len_bad;
    logic            w_crc_bad;
    logic [LW-1:0]   w_cnt_inc;

    assign w_crc_next = vfr_pkg::crc8_update(r_crc, i_byte);
    assign w_len_bad  = (i_byte < 8'(vfr_pkg::CAPTURE_BYTES)) || (i_byte > 8'(MAX_PAYLOAD));
    assign w_crc_bad  = (i_byte != r_crc);
    assign w_cnt_inc  = r_cnt + LW'(1);

    // Next state.
    always_comb begin
        n_phase = r_phase;
        n_prev  = r_prev;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_crc   = r_crc;
        unique case (r_phase)
            vfr_pkg::PH_LEN: begin
                if (w_len_bad) begin
                    n_phase = vfr_pkg::PH_HUNT;
                    n_prev  = '0;
                    n_len   = '0;
                    n_cnt   = '0;
                    n_crc   = '0;
                end else begin
                    n_crc   = w_crc_next;
                    n_len   = i_byte[LW-1:0];
                    n_cnt   = '0;
                    n_phase = vfr_pkg::PH_PAY;
                end
            end
            vfr_pkg::PH_PAY: begin
                n_crc = w_crc_next;
                n_cnt = w_cnt_inc;
                if (w_cnt_inc >= r_len) begin
                    n_phase = vfr_pkg::PH_CRC;
                end
            end
            vfr_pkg::PH_CRC: begin
                if (w_crc_bad) begin
                    n_phase = vfr_pkg::PH_HUNT;
                    n_prev  = '0;
                    n_len   = '0;
                    n_cnt   = '0;
                    n_crc   = '0;
                end else begin
                    n_phase = vfr_pkg::PH_TR0;
                end
            end
            vfr_pkg::PH_TR0: begin
                n_phase = vfr_pkg::PH_TR1;
            end
            vfr_pkg::PH_TR1: begin
                n_phase = vfr_pkg::PH_HUNT;
                n_prev  = '0;
                n_len   = '0;
                n_cnt   = '0;
                n_crc   = '0;
            end
            default: begin
                // Hunting, and any unused phase code behaves the same way.
                n_phase = vfr_pkg::PH_HUNT;
                if (i_byte == vfr_pkg::HDR1) begin
                    if (r_prev == vfr_pkg::HDR0) begin
                        n_crc   = vfr_pkg::CRC_HDR;
                        n_len   = '0;
                        n_cnt   = '0;
                        n_phase = vfr_pkg::PH_LEN;
                    end
                end else begin
                    n_prev = i_byte;
                end
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_evt.valid  = 1'b0;
        o_evt.status = vfr_pkg::ST_OK;
        for (int i = 0; i < vfr_pkg::CAPTURE_BYTES; i++) begin
            o_evt.payload[i] = r_payload[i];
        end
        unique case (r_phase)
            vfr_pkg::PH_LEN: begin
                o_evt.valid  = i_step && w_len_bad;
                o_evt.status = vfr_pkg::ST_LEN;
            end
            vfr_pkg::PH_CRC: begin
                o_evt.valid  = i_step && w_crc_bad;
                o_evt.status = vfr_pkg::ST_CRC;
            end
            vfr_pkg::PH_TR1: begin
                o_evt.valid  = i_step;
                o_evt.status = vfr_pkg::ST_OK;
            end
            default: begin
                o_evt.valid  = 1'b0;
                o_evt.status = vfr_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= vfr_pkg::PH_HUNT;
            r_prev  <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_crc   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_prev  <= n_prev;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_crc   <= n_crc;
        end
    end

    // Only the first payload bytes are kept; later ones only feed the CRC.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < vfr_pkg::CAPTURE_BYTES; i++) begin
            if (i_step && (r_phase == vfr_pkg::PH_PAY) && (r_cnt == LW'(i))) begin
                r_payload[i] <= i_byte;
            end
        end
    end

endmodule

### hdl/velocity_frame_receiver_crc8_unit.sv
// A result beat is registered when the parser steps on the byte that completes or rejects a frame.
// Throughput: one received byte per cycle while the result side is ready.
// Each byte passes an input register, the combinational parser and saturation logic, and the
// result register; the input register holds one byte while a result waits to be taken.
// Reset (synchronous, active low) returns to header hunting, empties both registers and
// sets the speed limit to 500.
module velocity_frame_receiver_crc8_unit #(
    parameter int MAX_PAYLOAD = vfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vfr_rx_if.sink      i_rx,
    vfr_res_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [14:0] i_cfg_wdata
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic [14:0]         r_speed_limit;
    logic                r_out_valid;
    vfr_pkg::t_status    r_out_status;
    logic signed [15:0]  r_out_left;
    logic signed [15:0]  r_out_right;
    logic [7:0]          r_out_flag;

    logic                w_advance;
    logic                w_accept;
    vfr_pkg::t_frame_evt w_evt;
    logic signed [15:0]  w_left;
    logic signed [15:0]  w_right;
    logic                w_ok;

    assign w_advance  = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || w_advance;
    assign w_accept   = i_rx.valid && i_rx.ready;

    vfr_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parser (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (w_advance),
        .i_byte (r_in_byte),
        .o_evt  (w_evt)
    );

    vfr_sat u_sat_left (
        .i_lo   (w_evt.payload[0]),
        .i_hi   (w_evt.payload[1]),
        .i_limit(r_speed_limit),
        .o_speed(w_left)
    );

    vfr_sat u_sat_right (
        .i_lo   (w_evt.payload[2]),
        .i_hi   (w_evt.payload[3]),
        .i_limit(r_speed_limit),
        .o_speed(w_right)
    );

    assign w_ok = (w_evt.status == vfr_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_speed_limit <= vfr_pkg::LIMIT_RESET;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance && w_evt.valid) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_speed_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (w_advance && w_evt.valid) begin
            r_out_status <= w_evt.status;
            r_out_left   <= w_ok ? w_left : 16'sd0;
            r_out_right  <= w_ok ? w_right : 16'sd0;
            r_out_flag   <= w_ok ? w_evt.payload[4] : 8'd0;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.left_speed  = r_out_left;
    assign o_res.right_speed = r_out_right;
    assign o_res.ctrl_flag   = r_out_flag;

endmodule

### hdl/vfr_checker.sv
module vfr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         i_status,
    input logic signed [15:0] i_left_speed,
    input logic signed [15:0] i_right_speed,
    input logic [7:0]         i_ctrl_flag
);

    // No result beat may be offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result offered right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_status) && $stable(i_left_speed)
                                          && $stable(i_right_speed) && $stable(i_ctrl_flag)))
        else $error("stalled result beat changed");

    // A rejected frame carries no speeds and no flag.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != 2'(vfr_pkg::ST_OK)))
            |-> (i_left_speed == 16'sd0 && i_right_speed == 16'sd0 && i_ctrl_flag == 8'd0))
        else $error("rejected frame carries nonzero fields");

    // Saturation never yields the most negative code, and status is a known code.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_status == 2'(vfr_pkg::ST_OK) || i_status == 2'(vfr_pkg::ST_CRC)
                          || i_status == 2'(vfr_pkg::ST_LEN))
                         && i_left_speed != -16'sd32768 && i_right_speed != -16'sd32768))
        else $error("result field out of range");

endmodule

bind velocity_frame_receiver_crc8_unit vfr_checker u_vfr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_status     (o_res.status),
    .i_left_speed (o_res.left_speed),
    .i_right_speed(o_res.right_speed),
    .i_ctrl_flag  (o_res.ctrl_flag)
);
